[hdl/ule_pkg.sv]
// Shared types, character codes and command words for the UART line editor.
// No dependencies; every other file imports this package.
`default_nettype none

package ule_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int CNT_W      = $clog2(LINE_DEPTH);
  // Longest command word plus one, so the character after it can be checked.
  localparam int KEEP       = 7;
  localparam int KEEP_W     = $clog2(KEEP);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;

  localparam logic [1:0] CMD_WHO     = 2'd0;
  localparam logic [1:0] CMD_STATUS  = 2'd1;
  localparam logic [1:0] CMD_HELP    = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [47:0] WORD_WHO    = 48'("WHO");
  localparam logic [47:0] WORD_STATUS = 48'("STATUS");
  localparam logic [47:0] WORD_HELP   = 48'("HELP");

  // One accepted byte and what it asks the output sequencer to send.
  typedef struct packed {
    logic [7:0] rx;
    logic [1:0] kind;
    logic [1:0] code;
  } job_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61:8'h7A]}) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // Text (first KEEP held chars, n held in total) ends at first NUL or at n.
  // The word holds len chars, first char in the highest used byte.
  function automatic logic word_match(input logic [KEEP*8-1:0] txt, input logic [31:0] n,
                                      input logic [47:0] word, input int len);
    logic ok;
    ok = (n >= 32'(len));
    for (int i = 0; i < KEEP - 1; i++) begin
      if (i < len) begin
        if (fold_case(txt[i*8 +: 8]) != word[(len-1-i)*8 +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    if (n != 32'(len) && txt[len*8 +: 8] != CH_NUL) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

[hdl/ule_line.sv]
// Line state: held character count and the leading characters of the line.
// Classifies each accepted byte and matches the command. Uses ule_pkg.
`default_nettype none

module ule_line (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  rx_byte,
  output ule_pkg::job_t    job
);
  import ule_pkg::*;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [KEEP*8-1:0]   head;
  logic [31:0]         count_ext;
  logic                is_end;
  logic                is_erase;
  logic                held;
  logic                do_store;
  logic [1:0]          code;

  assign count_ext = 32'(count);
  assign is_end    = rx_byte inside {CH_CR, CH_LF};
  assign is_erase  = rx_byte inside {CH_BS, CH_DEL};
  assign held      = (count != '0);
  assign do_store  = !is_end && !is_erase && (count_ext < 32'(LINE_DEPTH - 1));

  always_comb begin
    if (word_match(head, count_ext, WORD_WHO, 3)) begin
      code = CMD_WHO;
    end else if (word_match(head, count_ext, WORD_STATUS, 6)) begin
      code = CMD_STATUS;
    end else if (word_match(head, count_ext, WORD_HELP, 4)) begin
      code = CMD_HELP;
    end else begin
      code = CMD_UNKNOWN;
    end
  end

  always_comb begin
    job.rx   = rx_byte;
    job.code = code;
    job.kind = KIND_ECHO;
    count_next = count;
    if (is_end && held) begin
      job.kind   = KIND_LINE;
      count_next = '0;
    end else if (is_erase && held) begin
      job.kind   = KIND_ERASE;
      count_next = count - 1'b1;
    end else if (do_store) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

  // Only the first KEEP positions matter for matching; later chars are counted only.
  always_ff @(posedge clk) begin
    if (take && do_store && count_ext < 32'(KEEP)) begin
      head[count_ext[KEEP_W-1:0]*8 +: 8] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

[hdl/ule_seq.sv]
// Output sequencer: one job register and a result register.
// Emits one or four results per job. Uses ule_pkg.
`default_nettype none

module ule_seq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ule_pkg::job_t job_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             command_event,
  output logic [1:0]       command_code,
  output logic             last
);
  import ule_pkg::*;

  job_t        job;
  logic        job_valid;
  logic [1:0]  idx;
  logic [1:0]  last_idx;
  logic        out_free;
  logic        load;
  logic        job_done;
  logic        take;
  logic [7:0]  r_byte;
  logic        r_bvalid;
  logic        r_event;
  logic [1:0]  r_code;
  logic        r_last;

  assign last_idx = (job.kind == KIND_ECHO) ? 2'd0 : 2'd3;
  assign out_free = !out_valid || !out_stall;
  assign load     = job_valid && out_free;
  assign job_done = load && (idx == last_idx);
  assign in_stall = job_valid && !job_done;
  assign take     = in_valid && !in_stall;

  always_comb begin
    r_byte   = job.rx;
    r_bvalid = 1'b1;
    r_event  = 1'b0;
    r_code   = CMD_WHO;
    r_last   = (idx == last_idx);
    case (idx)
      2'd0: r_byte = job.rx;
      2'd1: r_byte = (job.kind == KIND_LINE) ? CH_CR : CH_BS;
      2'd2: r_byte = (job.kind == KIND_LINE) ? CH_LF : CH_SPACE;
      2'd3: begin
        if (job.kind == KIND_LINE) begin
          r_byte   = CH_NUL;
          r_bvalid = 1'b0;
          r_event  = 1'b1;
          r_code   = job.code;
        end else begin
          r_byte = CH_BS;
        end
      end
      default: r_byte = job.rx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      job_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end else if (load) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= r_byte;
      out_byte_valid <= r_bvalid;
      command_event  <= r_event;
      command_code   <= r_code;
      last           <= r_last;
    end
  end

endmodule

`default_nettype wire

[hdl/uart_line_editor_command_match.sv]
// UART line editor with command matching: top level over ule_line and ule_seq.
// The job register is loaded on the input transfer; the first result moves into the
// result register once that register is free, and can transfer from there.
// Throughput: a byte with a single result every cycle while out_stall is low; a line
// end or erase on a non-empty line gives 4 results, one per cycle while not stalled.
// Reset (rst, synchronous): empty line, no job, no result pending.
`default_nettype none

module uart_line_editor_command_match (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            command_event,
  output logic [1:0]      command_code,
  output logic            last
);
  import ule_pkg::*;

  job_t job;
  logic take;

  // A transfer on the input channel updates the line state in the same edge
  // as the job register is loaded.
  assign take = in_valid && !in_stall;

  // Line state, byte classification and command match
  ule_line u_line (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .job     (job)
  );

  // Job register plus result register; the next byte is taken in the cycle
  // the last result of the current job moves into the result register.
  ule_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .job_in         (job),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .command_event  (command_event),
    .command_code   (command_code),
    .last           (last)
  );

endmodule

`default_nettype wire

[hdl/ule_check.sv]
// Port-level checker for the line editor, bound to the top level.
// Uses ule_pkg for character codes.
`default_nettype none

module ule_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       command_event,
  input wire logic [1:0] command_code,
  input wire logic       last
);
  import ule_pkg::*;

  // command event carries no byte and closes its sequence
  a_event_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_event |-> !out_byte_valid && last)
    else $error("command event with byte or not last");

  // ordinary results carry a byte and a zero code
  a_plain_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !command_event |-> out_byte_valid && command_code == CMD_WHO)
    else $error("plain result without byte or with code");

  // space inside an erase sequence is followed at once by the closing BS
  a_erase_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last && out_byte == CH_SPACE |=>
      out_valid && out_byte == CH_BS && last)
    else $error("erase sequence broken");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

endmodule

bind uart_line_editor_command_match ule_check u_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .command_event  (command_event),
  .command_code   (command_code),
  .last           (last)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for uart_line_editor_command_match.
// A scoreboard class predicts echo, erase, line-end and command results per
// received byte; needs ule_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
  import ule_pkg::*;

  localparam int ITEM_TARGET  = 310;  // input transfers before the stimulus stops
  localparam int TAIL_ITEMS   = 40;   // last stretch runs with no idling at all
  localparam int DRAIN_AT     = 110;  // sender waits for every result here once
  localparam int HOLD_AT      = 200;  // long receiver hold-off starts here once
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000; // cycles with no transfer on either side
  localparam int TAIL_CYCLES  = 16;
  localparam int PRINT_LIMIT  = 40;

  // Non-event results carry this code.
  localparam logic [1:0] NO_CODE = CMD_WHO;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       is_event;
    logic [1:0] code;
    logic       is_last;
  } editor_result_t;

  // Line editor predictor plus the queue of results still owed by the block.
  class line_editor_scoreboard;
    logic [7:0]     held_chars[LINE_DEPTH];
    int unsigned    held_count;
    editor_result_t owed[$];
    int             errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    function automatic bit text_equals(logic [7:0] text[$], string word);
      if (text.size() != word.len()) return 1'b0;
      for (int i = 0; i < word.len(); i++) begin
        if (text[i] != word[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Held text up to the first NUL, a-z folded up, compared whole.
    function automatic logic [1:0] command_of_line();
      logic [7:0] folded[$];
      logic [7:0] c;
      for (int i = 0; i < held_count; i++) begin
        c = held_chars[i];
        if (c == CH_NUL) break;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
        folded.push_back(c);
      end
      if (text_equals(folded, "WHO")) return CMD_WHO;
      if (text_equals(folded, "STATUS")) return CMD_STATUS;
      if (text_equals(folded, "HELP")) return CMD_HELP;
      return CMD_UNKNOWN;
    endfunction

    function automatic void owe(logic [7:0] b, logic v, logic ev, logic [1:0] code,
                                logic fin);
      editor_result_t r;
      r.tx_byte  = b;
      r.tx_valid = v;
      r.is_event = ev;
      r.code     = code;
      r.is_last  = fin;
      owed.push_back(r);
    endfunction

    // One accepted input transfer.
    function automatic void note_input(logic [7:0] b);
      logic [1:0] code;
      if (b == CH_CR || b == CH_LF) begin
        if (held_count > 0) begin
          code = command_of_line();
          owe(b, 1'b1, 1'b0, NO_CODE, 1'b0);
          owe(CH_CR, 1'b1, 1'b0, NO_CODE, 1'b0);
          owe(CH_LF, 1'b1, 1'b0, NO_CODE, 1'b0);
          owe(CH_NUL, 1'b0, 1'b1, code, 1'b1);
          held_count = 0;
          return;
        end
      end else if (b == CH_BS || b == CH_DEL) begin
        if (held_count > 0) begin
          held_count--;
          owe(b, 1'b1, 1'b0, NO_CODE, 1'b0);
          owe(CH_BS, 1'b1, 1'b0, NO_CODE, 1'b0);
          owe(CH_SPACE, 1'b1, 1'b0, NO_CODE, 1'b0);
          owe(CH_BS, 1'b1, 1'b0, NO_CODE, 1'b1);
          return;
        end
      end else if (held_count < LINE_DEPTH - 1) begin
        held_chars[held_count] = b;
        held_count++;
      end
      // full line lands here too: echoed, not stored
      owe(b, 1'b1, 1'b0, NO_CODE, 1'b1);
    endfunction

    task automatic report(string msg);
      if (errors < PRINT_LIMIT) $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    // One accepted result transfer against the oldest owed result.
    task automatic check_result(editor_result_t got);
      editor_result_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed, out_byte %h", got.tx_byte));
        return;
      end
      want = owed.pop_front();
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("out_byte %h, want %h", got.tx_byte, want.tx_byte));
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("out_byte_valid %b, want %b", got.tx_valid, want.tx_valid));
      if (got.is_event !== want.is_event)
        report($sformatf("command_event %b, want %b", got.is_event, want.is_event));
      if (got.code !== want.code)
        report($sformatf("command_code %0d, want %0d", got.code, want.code));
      if (got.is_last !== want.is_last)
        report($sformatf("last %b, want %b", got.is_last, want.is_last));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       command_event;
  logic [1:0] command_code;
  logic       last;

  line_editor_scoreboard sb;
  int  items_sent;
  bit  tail_phase;   // no idling on either side once set
  bit  hold_req;     // raised by the sender, cleared by the stall process

  uart_line_editor_command_match u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .command_event (command_event),
    .command_code  (command_code),
    .last          (last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // --- input side -----------------------------------------------------------

  // Drop valid for an idle stretch set by n; the payload is free to wander while invalid.
  task automatic idle_input(int n);
    @(negedge clk);
    in_valid = 1'b0;
    rx_byte  = 8'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one byte and hold it until the transfer. Valid stays high afterwards
  // so back-to-back bytes never drop it in between.
  task automatic send_byte(logic [7:0] b);
    if (!tail_phase && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 19));
    @(negedge clk);
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
    items_sent++;
  endtask

  // Sender pause: nothing offered until every owed result has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_case(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) return c + 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] random_erase();
    return ($urandom_range(0, 1) == 1) ? CH_DEL : CH_BS;
  endfunction

  function automatic logic [7:0] random_letter();
    return random_case(8'($urandom_range(8'h41, 8'h5A)));
  endfunction

  // One random line. Mostly command words with small damage, so the matcher
  // sees near misses; also overflowing lines, erase storms and raw noise.
  task automatic send_random_line();
    logic [7:0] seq[$];
    string      word;
    int         kind;
    int         pick;
    int         cut;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      pick = $urandom_range(0, 2);
      case (pick)
        0: word = "WHO";
        1: word = "STATUS";
        default: word = "HELP";
      endcase
      for (int i = 0; i < word.len(); i++) seq.push_back(random_case(word[i]));
      case ($urandom_range(0, 5))
        1: void'(seq.pop_back());
        2: seq.push_back(random_letter());
        3: begin
          // NUL cuts the command text; junk after it must not matter
          seq.push_back(CH_NUL);
          repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          // typo fixed in place: stray letter then an erase
          cut = $urandom_range(0, seq.size());
          seq.insert(cut, random_erase());
          seq.insert(cut, random_letter());
        end
        5: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (kind == 5) begin
      // near or past the line limit: bytes beyond it are echoed and dropped
      repeat ($urandom_range(LINE_DEPTH - 3, LINE_DEPTH + 6))
        seq.push_back(8'($urandom_range(8'h21, 8'h7E)));
      if ($urandom_range(0, 1) == 1) begin
        seq.push_back(random_erase());
        seq.push_back(random_letter());
      end
    end else if (kind == 6) begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 7) begin
      // erase-heavy; may erase past the start of the line
      repeat ($urandom_range(1, 5)) begin
        seq.push_back(random_letter());
        if ($urandom_range(0, 1) == 1) seq.push_back(random_erase());
      end
      repeat ($urandom_range(0, 3)) seq.push_back(random_erase());
    end else begin
      repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    if (kind != 6) seq.push_back(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // --- result side ----------------------------------------------------------

  // Random stall bursts, one long hold-off on request, none in the tail.
  initial begin : result_stall
    int burst_left;
    bit burst_stall;
    int hold_count;
    burst_left  = 0;
    burst_stall = 1'b0;
    hold_count  = 0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        hold_count++;
        if (hold_count == HOLD_CYCLES) begin
          hold_req   = 1'b0;
          hold_count = 0;
        end
      end else if (tail_phase) begin
        out_stall = 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left  = $urandom_range(1, 19);
          burst_stall = ($urandom_range(0, 2) == 0);
        end
        out_stall = burst_stall;
        burst_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({out_byte, out_byte_valid, command_event, command_code, last});
  end

  // Ends the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("uart_line_editor_command_match verification failed");
    $finish;
  end

  // --- main sequence --------------------------------------------------------

  initial begin : stimulus
    logic [7:0] directed[$];
    bit drain_done;
    bit hold_done;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = 8'h00;
    tail_phase = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    drain_done = 1'b0;
    hold_done  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: line end and erase on an empty line, each word in mixed or lower case,
    // NUL ending the command with a high byte after it, an erase mid-line
    // leaving an unknown word.
    directed = '{CH_CR, CH_BS, CH_DEL,
                 "w", "H", "o", CH_CR,
                 "s", "T", "a", "T", "u", "S", CH_LF,
                 "h", "e", "l", "p", CH_NUL, 8'hFF, CH_CR,
                 "h", "X", CH_DEL, "Z", CH_CR};
    foreach (directed[i]) send_byte(directed[i]);

    while (items_sent < ITEM_TARGET) begin
      if (!drain_done && items_sent >= DRAIN_AT) begin
        drain_results();
        drain_done = 1'b1;
      end
      // receiver holds off while we keep offering, so the block backs up
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent >= ITEM_TARGET - TAIL_ITEMS) tail_phase = 1'b1;
      send_random_line();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    // catch stray results after the last owed one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("uart_line_editor_command_match verification clean");
    end else begin
      $display("uart_line_editor_command_match verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ule_pkg.sv
hdl/ule_line.sv
hdl/ule_seq.sv
hdl/uart_line_editor_command_match.sv
hdl/ule_check.sv
tb/tb_top.sv
